// ----- design/assert_macros.svh -----
// Assertion macros used by the admission limiter RTL.
// Users must have clk and rst_n in scope; SYNTH strips the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_PROP(label, !(cond), msg)
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- design/cawf_pkg.sv -----
// Shared types, codes and helpers for the credit admission limiter.
// No dependencies.
`default_nettype none
package cawf_pkg;

    localparam int WAIT_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF   = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CFG_WIDTH      = 16;

    typedef enum logic [2:0] {
        KIND_RESERVE      = 3'd0,
        KIND_COMPLETE_RSV = 3'd1,
        KIND_CANCEL_RSV   = 3'd2,
        KIND_COMPLETE_REQ = 3'd3,
        KIND_CLEAR        = 3'd4
    } kind_e_t;

    typedef enum logic [1:0] {
        OUT_GRANTED  = 2'd0,
        OUT_QUEUED   = 2'd1,
        OUT_REJECTED = 2'd2,
        OUT_DRAINED  = 2'd3
    } outcome_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DRAIN
    } state_t;

    localparam logic CFG_READ_AHEAD      = 1'b0;
    localparam logic CFG_MAX_IN_PROGRESS = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] waiter_id;
        logic [15:0] request_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] granted_waiter;
        logic        last;
    } result_t;

    // Zero limit means unlimited.
    function automatic logic has_capacity(input logic [15:0] lim,
                                          input logic [31:0] infl,
                                          input logic [15:0] rsv);
        logic [32:0] load;
        load = 33'(infl) + 33'(rsv);
        return (lim == 16'd0) || (load < 33'(lim));
    endfunction

endpackage
`default_nettype wire

// ----- design/credit_admission_with_wait_fifo_top.sv -----
// Top level of the credit admission limiter with a FIFO of waiters.
// Depends on cawf_pkg, cawf_ctrl and cawf_queue_mem.
`default_nettype none
// Command in on start/busy, results out on result_valid, one cycle each; the
// receiver cannot stall, so every result must be taken the cycle it shows.
// A reserve, clear or unused kind leaves busy low, so the next command may
// follow at once; a reserve's result shows the cycle after.
// Complete/cancel commands keep busy high through a capacity check state, then
// one grant per cycle for each queued waiter granted (at most 16), paced by
// the single read port of the waiter memory; the next command is taken once
// busy falls.
// Each grant shows the cycle after its drain cycle. No reset sweep is needed;
// the queue memory is tracked by its fill.
module credit_admission_with_wait_fifo_top
    import cawf_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire cmd_t                 cmd,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_data,
    output logic                      result_valid,
    output result_t                   result
);

    localparam int PW = $clog2(WAIT_DEPTH);

    logic                mem_we;
    logic [PW-1:0]       mem_waddr;
    logic [ID_WIDTH-1:0] mem_wdata;
    logic [PW-1:0]       mem_raddr;
    logic [ID_WIDTH-1:0] mem_rdata;

    cawf_ctrl #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    cawf_queue_mem #(
        .DEPTH (WAIT_DEPTH),
        .WIDTH (ID_WIDTH)
    ) u_queue (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

// ----- design/cawf_queue_mem.sv -----
// Waiter FIFO storage: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module cawf_queue_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- design/cawf_ctrl.sv -----
// Admission control: counters, queue pointers, command decode and drain FSM.
// Depends on cawf_pkg and assert_macros.svh; drives cawf_queue_mem.
`default_nettype none
`include "assert_macros.svh"
module cawf_ctrl
    import cawf_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire cmd_t                          cmd,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [CFG_WIDTH-1:0]          cfg_data,
    output logic                               result_valid,
    output result_t                            result,
    output logic                               mem_we,
    output logic [$clog2(WAIT_DEPTH)-1:0]      mem_waddr,
    output logic [ID_WIDTH-1:0]                mem_wdata,
    output logic [$clog2(WAIT_DEPTH)-1:0]      mem_raddr,
    input  wire logic [ID_WIDTH-1:0]           mem_rdata
);

    localparam int PW = $clog2(WAIT_DEPTH);
    localparam int FW = $clog2(WAIT_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    state_t         state_reg, state_next;
    logic           rae_reg, rae_next;
    logic [15:0]    max_reg, max_next;
    logic [15:0]    res_reg, res_next;
    logic [31:0]    infl_reg, infl_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [NW-1:0]  n_reg, n_next;
    logic           result_valid_reg, result_valid_next;
    result_t        result_reg, result_next;

    logic           accept;
    logic           cap_now;
    logic           cond_now;
    logic           cond_after;
    logic [15:0]    res_inc;
    logic [15:0]    res_dec;
    logic [PW-1:0]  head_inc;
    logic [FW:0]    tail_sum;
    logic [PW-1:0]  tail;
    logic [ID_WIDTH-1:0] id_in;
    logic [32:0]    infl_sum;
    logic [31:0]    cnt_ext;

    logic           in_drain;
    logic           drained_out;
    logic           last_out;
    logic           reserve_acc;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && (state_reg == ST_IDLE);
    assign id_in    = ID_WIDTH'(cmd.waiter_id);
    assign cnt_ext  = 32'(cmd.request_count);
    assign infl_sum = 33'(infl_reg) + 33'(cnt_ext);

    assign res_inc  = (res_reg != 16'hFFFF) ? res_reg + 16'd1 : res_reg;
    assign res_dec  = (res_reg != 16'd0) ? res_reg - 16'd1 : res_reg;
    assign head_inc = (head_reg == PW'(WAIT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = (FW + 1)'(head_reg) + (FW + 1)'(fill_reg);
    assign tail     = (tail_sum >= (FW + 1)'(WAIT_DEPTH))
                    ? PW'(tail_sum - (FW + 1)'(WAIT_DEPTH)) : PW'(tail_sum);

    assign cap_now  = has_capacity(max_reg, infl_reg, res_reg);
    assign cond_now = (fill_reg != '0) && cap_now;
    // In DRAIN every cycle is a grant; look one grant ahead to mark last.
    assign cond_after = (fill_reg != FW'(1))
                     && ((n_reg + 1'b1) < NW'(MAX_RESULTS))
                     && has_capacity(max_reg, infl_reg, res_inc);

    // Read is issued at head, or at the next head while draining; writes only land while idle, before any drain read.
    assign mem_raddr = (state_reg == ST_DRAIN) ? head_inc : head_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.kind) inside
                        KIND_COMPLETE_RSV, KIND_CANCEL_RSV, KIND_COMPLETE_REQ:
                            state_next = ST_CHECK;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CHECK:
                state_next = cond_now ? ST_DRAIN : ST_IDLE;
            ST_DRAIN:
                state_next = cond_after ? ST_DRAIN : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rae_next          = rae_reg;
        max_next          = max_reg;
        res_next          = res_reg;
        infl_next         = infl_reg;
        head_next         = head_reg;
        fill_next         = fill_reg;
        n_next            = n_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_waddr         = tail;
        mem_wdata         = id_in;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_READ_AHEAD:      rae_next = cfg_data[0];
                CFG_MAX_IN_PROGRESS: max_next = cfg_data[15:0];
                default:             ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next = '0;
                    unique case (cmd.kind)
                        KIND_RESERVE:
                        begin
                            result_valid_next          = 1'b1;
                            result_next.granted_waiter = 16'(id_in);
                            result_next.last           = 1'b1;
                            if (!rae_reg || (max_reg == 16'd0)
                                || ((fill_reg == '0) && cap_now))
                            begin
                                res_next            = res_inc;
                                result_next.outcome = OUT_GRANTED;
                            end
                            else if (fill_reg < FW'(WAIT_DEPTH))
                            begin
                                mem_we              = 1'b1;
                                fill_next           = fill_reg + 1'b1;
                                result_next.outcome = OUT_QUEUED;
                            end
                            else
                            begin
                                result_next.outcome = OUT_REJECTED;
                            end
                        end
                        KIND_COMPLETE_RSV:
                        begin
                            res_next  = res_dec;
                            infl_next = infl_sum[32] ? 32'hFFFF_FFFF : infl_sum[31:0];
                        end
                        KIND_CANCEL_RSV:
                            res_next = res_dec;
                        KIND_COMPLETE_REQ:
                            infl_next = (infl_reg > cnt_ext) ? infl_reg - cnt_ext : 32'd0;
                        KIND_CLEAR:
                        begin
                            fill_next = '0;
                            head_next = '0;
                        end
                        default:
                            ;
                    endcase
                end
            end
            ST_CHECK:
                ;
            ST_DRAIN:
            begin
                result_valid_next          = 1'b1;
                result_next.outcome        = OUT_DRAINED;
                result_next.granted_waiter = 16'(mem_rdata);
                result_next.last           = !cond_after;
                head_next                  = head_inc;
                fill_next                  = fill_reg - 1'b1;
                res_next                   = res_inc;
                n_next                     = n_reg + 1'b1;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rae_reg          <= 1'b0;
            max_reg          <= '0;
            res_reg          <= '0;
            infl_reg         <= '0;
            head_reg         <= '0;
            fill_reg         <= '0;
            n_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rae_reg          <= rae_next;
            max_reg          <= max_next;
            res_reg          <= res_next;
            infl_reg         <= infl_next;
            head_reg         <= head_next;
            fill_reg         <= fill_next;
            n_reg            <= n_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign in_drain    = (state_reg == ST_DRAIN);
    assign drained_out = result_valid_reg && (result_reg.outcome == OUT_DRAINED);
    assign last_out    = result_valid_reg && result_reg.last;
    assign reserve_acc = accept && (cmd.kind == KIND_RESERVE);

    `ASSERT_PROP(a_fill_bound, fill_reg <= FW'(WAIT_DEPTH), "queue fill above depth")
    `ASSERT_PROP(a_drain_nonempty, in_drain |-> (fill_reg != '0), "drain on empty queue")
    `ASSERT_PROP(a_grant_bound, n_reg <= NW'(MAX_RESULTS), "too many grants for one item")
    `ASSERT_PROP(a_drain_src, drained_out |-> $past(in_drain), "grant outside drain")
    `ASSERT_PROP(a_reserve_one, reserve_acc |=> last_out, "reserve without result")

endmodule
`default_nettype wire

// ----- tb/sv/credit_admission_with_wait_fifo_top_test.sv -----
// Self-checking testbench for credit_admission_with_wait_fifo_top.
// Needs cawf_pkg and the limiter RTL; a built-in scoreboard predicts every result.
`timescale 1ns / 100ps
module credit_admission_with_wait_fifo_top_test
    import cawf_pkg::*;
();

    localparam logic [2:0] KIND_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] KIND_LAST_UNUSED  = 3'd7;
    localparam int RAND_PHASES = 7;
    localparam int RAND_ITEMS  = 36;
    localparam int CYCLE_LIMIT = 1_000_000;

    // Shadow of the limiter: counts, waiter FIFO, and the results still owed.
    class admission_tracker;
        bit              read_ahead;
        bit [15:0]       limit;
        bit [15:0]       rsv_count;
        bit [31:0]       inflight;
        bit [15:0]       waiters [16];
        bit [3:0]        head;
        bit [4:0]        fill;
        result_t         owed_q[$];
        int              errors;
        int              items;
        int              results;
        int              drained;

        function void set_register(logic idx, logic [15:0] data);
            if (idx == CFG_READ_AHEAD)
                read_ahead = data[0];
            else
                limit = data;
        endfunction

        function bit has_room();
            return (limit == 16'd0) || ({1'b0, inflight} + 33'(rsv_count) < 33'(limit));
        endfunction

        function void add_reservation();
            if (rsv_count != 16'hFFFF)
                rsv_count++;
        endfunction

        function void drop_reservation();
            if (rsv_count != 16'd0)
                rsv_count--;
        endfunction

        function void owe(outcome_e_t oc, bit [15:0] id, bit last);
            result_t r;
            r.outcome        = oc;
            r.granted_waiter = id;
            r.last           = last;
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void drain_waiters();
            int      n;
            result_t fin;
            n = 0;
            while (fill != 0 && n < MAX_RESULTS && has_room())
            begin
                owe(OUT_DRAINED, waiters[head], 1'b0);
                head++;
                fill--;
                add_reservation();
                n++;
            end
            if (n > 0)
            begin
                fin = owed_q[owed_q.size() - 1];
                fin.last = 1'b1;
                owed_q[owed_q.size() - 1] = fin;
            end
        endfunction

        function void note_command(cmd_t c);
            bit [32:0] sum;
            items++;
            case (c.kind)
                KIND_RESERVE:
                    if (!read_ahead || limit == 16'd0 || (fill == 0 && has_room()))
                    begin
                        add_reservation();
                        owe(OUT_GRANTED, c.waiter_id, 1'b1);
                    end
                    else if (fill < 16)
                    begin
                        waiters[head + fill[3:0]] = c.waiter_id;
                        fill++;
                        owe(OUT_QUEUED, c.waiter_id, 1'b1);
                    end
                    else
                    begin
                        owe(OUT_REJECTED, c.waiter_id, 1'b1);
                    end
                KIND_COMPLETE_RSV:
                begin
                    drop_reservation();
                    sum = {1'b0, inflight} + 33'(c.request_count);
                    inflight = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    drain_waiters();
                end
                KIND_CANCEL_RSV:
                begin
                    drop_reservation();
                    drain_waiters();
                end
                KIND_COMPLETE_REQ:
                begin
                    inflight = (inflight > 32'(c.request_count)) ?
                               inflight - 32'(c.request_count) : 32'd0;
                    drain_waiters();
                end
                KIND_CLEAR:
                begin
                    fill = 0;
                    head = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t r);
            result_t e;
            results++;
            if (owed_q.size() == 0)
            begin
                $error("unexpected result: outcome %0d waiter %h last %0d",
                       r.outcome, r.granted_waiter, r.last);
                errors++;
                return;
            end
            e = owed_q[0];
            owed_q.delete(0);
            if (e.outcome == OUT_DRAINED)
                drained++;
            if (r.outcome !== e.outcome)
            begin
                $error("outcome: expected %0d, got %0d", e.outcome, r.outcome);
                errors++;
            end
            if (r.granted_waiter !== e.granted_waiter)
            begin
                $error("granted_waiter: expected %h, got %h",
                       e.granted_waiter, r.granted_waiter);
                errors++;
            end
            if (r.last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, r.last);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    cmd_t            cmd = '0;
    logic            cfg_we = 1'b0;
    logic            cfg_index = 1'b0;
    logic [15:0]     cfg_data = '0;
    logic            result_valid;
    result_t         result;

    admission_tracker tracker = new;
    bit              gaps_on = 1'b1;
    int              cycle_count = 0;

    credit_admission_with_wait_fifo_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            tracker.check_result(result);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, tracker.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_cmd(input logic [2:0] kind, input logic [15:0] id,
                            input logic [15:0] count);
        cmd_t c;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        c.kind          = kind;
        c.waiter_id     = id;
        c.request_count = count;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        tracker.note_command(c);
    endtask

    // A count-only command that grants nothing may still be in its check cycle.
    task automatic wait_quiet();
        start <= 1'b0;
        while (tracker.pending() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_limits(input logic [15:0] ra_data, input logic [15:0] lim);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_READ_AHEAD;
        cfg_data  <= ra_data;
        @(posedge clk);
        tracker.set_register(CFG_READ_AHEAD, ra_data);
        cfg_index <= CFG_MAX_IN_PROGRESS;
        cfg_data  <= lim;
        @(posedge clk);
        tracker.set_register(CFG_MAX_IN_PROGRESS, lim);
        cfg_we    <= 1'b0;
    endtask

    // Mostly tiny counts so capacity hovers near the limit; now and then a full-range one.
    function automatic logic [15:0] pick_count(int top);
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, top));
    endfunction

    task automatic random_cmd();
        int         r;
        logic [2:0] k;
        r = $urandom_range(0, 99);
        if (r < 45)
            k = KIND_RESERVE;
        else if (r < 60)
            k = KIND_COMPLETE_RSV;
        else if (r < 78)
            k = KIND_CANCEL_RSV;
        else if (r < 93)
            k = KIND_COMPLETE_REQ;
        else if (r < 97)
            k = KIND_CLEAR;
        else
            k = 3'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
        send_cmd(k, 16'($urandom), pick_count(r < 60 ? 2 : 4));
    endtask

    initial
    begin
        logic [15:0] lim;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // no queuing: every reserve granted; count updates, clamps at zero
        program_limits(16'd0, 16'd0);
        send_cmd(KIND_RESERVE, 16'h0000, 16'hFFFF);
        send_cmd(KIND_RESERVE, 16'hFFFF, 16'h0000);
        send_cmd(KIND_COMPLETE_RSV, 16'h5A5A, 16'h0000);
        send_cmd(KIND_COMPLETE_REQ, 16'h0000, 16'hFFFF);
        send_cmd(KIND_CANCEL_RSV, 16'hFFFF, 16'h0000);
        send_cmd(KIND_CANCEL_RSV, 16'h0000, 16'h0000);
        send_cmd(KIND_CLEAR, 16'h1234, 16'h4321);
        send_cmd(KIND_FIRST_UNUSED, 16'hFFFF, 16'hFFFF);

        // limit of one: first reserve granted, then fill the queue, then overflow
        program_limits(16'd1, 16'd1);
        repeat (18) send_cmd(KIND_RESERVE, 16'($urandom), 16'($urandom));
        // room for the whole queue at once: sixteen grants from one command
        program_limits(16'hFFFF, 16'd17);
        send_cmd(KIND_COMPLETE_REQ, 16'($urandom), 16'd0);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            gaps_on = (p != RAND_PHASES - 1);
            case (p)
                0: lim = 16'd2;
                1: lim = 16'd1;
                2: lim = 16'($urandom);
                3: lim = 16'hFFFF;
                4: lim = 16'd0;
                5: lim = 16'd3;
                default: lim = 16'($urandom_range(1, 8));
            endcase
            program_limits({15'($urandom), 1'(p != 2)}, lim);
            repeat (RAND_ITEMS) random_cmd();
        end

        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (tracker.pending() != 0)
        begin
            $error("%0d expected results never arrived", tracker.pending());
            tracker.errors++;
        end
        $display("%0d commands over %0d limit settings, %0d results checked (%0d queue grants)",
                 tracker.items, RAND_PHASES + 3, tracker.results, tracker.drained);
        $display("random phases: %0d of %0d commands each, %0d mismatches",
                 RAND_PHASES, RAND_ITEMS, tracker.errors);
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/cawf_pkg.sv
design/cawf_queue_mem.sv
design/cawf_ctrl.sv
design/credit_admission_with_wait_fifo_top.sv
tb/sv/credit_admission_with_wait_fifo_top_test.sv
